FILE: rtl/epsm_pkg.sv
`default_nettype none
package epsm_pkg;

    typedef enum logic [2:0] {
        FN_PULSE = 3'd0,
        FN_INDEX = 3'd1,
        FN_CAL_REQ = 3'd2,
        FN_LOAD_CORR = 3'd3,
        FN_SPEED = 3'd4,
        FN_READ_CAP = 3'd5
    } t_func;

    localparam logic CFG_CORR_EN = 1'b0;
    localparam logic CFG_REVERSE = 1'b1;

    localparam int DIV_W = 64;
    localparam logic [27:0] RPM_NUM = 28'd153600000;
    localparam logic [39:0] RAD_NUM_Q16 = 40'd1054143570666;
    localparam logic [15:0] PCT_NEUTRAL = 16'd100;

    // table port controls from the sequencer
    typedef struct packed {
        logic clear;     // start capture clearing pass
        logic cap_we;
        logic corr_we;
    } t_tbl_ctl;

endpackage
`default_nettype wire

FILE: rtl/epsm_div.sv
`default_nettype none
module epsm_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [epsm_pkg::DIV_W-1:0] i_num,
    input  wire logic [epsm_pkg::DIV_W-1:0] i_den,
    output logic                            o_done,
    output logic [31:0]                     o_quot
);
    import epsm_pkg::*;

    // restoring division, one quotient bit a cycle; first step checks overflow
    logic                r_busy;
    logic [5:0]          r_cnt;
    logic [DIV_W-1:0]    r_rem;
    logic [DIV_W+31:0]   r_d;
    logic [31:0]         r_q;
    logic                r_sat;
    logic                ge;

    assign ge = {32'b0, r_rem} >= r_d;
    assign o_quot = r_sat ? 32'hFFFF_FFFF : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            o_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= i_num;
            r_d    <= {i_den, 32'b0};
            r_q    <= '0;
            r_sat  <= 1'b0;
        end else if (r_busy) begin
            r_d <= r_d >> 1;
            if (r_cnt == 6'd0) begin
                r_sat <= ge;
            end else begin
                r_q <= {r_q[30:0], ge};
                if (ge) begin
                    r_rem <= r_rem - r_d[DIV_W-1:0];
                end
            end
            o_done <= (r_cnt == 6'd32);
            if (r_cnt == 6'd32) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 6'd1;
        end else begin
            o_done <= 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/epsm_tables.sv
`default_nettype none
module epsm_tables #(
    parameter int SECTORS  = 64,
    parameter int CAL_REVS = 8,
    parameter int CAW      = 9,
    parameter int CRW      = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire epsm_pkg::t_tbl_ctl   i_ctl,
    input  wire logic [CAW-1:0]       i_cap_waddr,
    input  wire logic [31:0]          i_cap_wdata,
    input  wire logic [CAW-1:0]       i_cap_raddr,
    output logic [31:0]               o_cap_rdata,
    input  wire logic [CRW-1:0]       i_corr_waddr,
    input  wire logic [15:0]          i_corr_wdata,
    input  wire logic [CRW-1:0]       i_corr_raddr,
    output logic [15:0]               o_corr_rdata,
    output logic                      o_busy
);
    import epsm_pkg::*;

    localparam int CDEPTH = SECTORS * CAL_REVS;
    localparam int RDEPTH = 2 * SECTORS;
    localparam int MAXD   = (CDEPTH > RDEPTH) ? CDEPTH : RDEPTH;
    localparam int CW     = $clog2(MAXD);

    logic [31:0] cap_mem [CDEPTH];
    logic [15:0] corr_mem [RDEPTH];

    logic          r_sweep;
    logic          r_clr_corr;
    logic [CW-1:0] r_cnt;
    logic          cap_we, corr_we;
    logic [CAW-1:0] cap_wa;
    logic [CRW-1:0] corr_wa;
    logic [31:0]    cap_wd;
    logic [15:0]    corr_wd;

    assign o_busy = r_sweep;

    always_comb begin
        if (r_sweep) begin
            cap_we  = {1'b0, r_cnt} < (CW+1)'(CDEPTH);
            corr_we = r_clr_corr && ({1'b0, r_cnt} < (CW+1)'(RDEPTH));
            cap_wa  = CAW'(r_cnt);
            corr_wa = CRW'(r_cnt);
            cap_wd  = '0;
            corr_wd = PCT_NEUTRAL;
        end else begin
            cap_we  = i_ctl.cap_we;
            corr_we = i_ctl.corr_we;
            cap_wa  = i_cap_waddr;
            corr_wa = i_corr_waddr;
            cap_wd  = i_cap_wdata;
            corr_wd = i_corr_wdata;
        end
    end

    // reset sweep fills both tables; calibration start clears captures only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep    <= 1'b1;
            r_clr_corr <= 1'b1;
            r_cnt      <= '0;
        end else if (r_sweep) begin
            r_cnt <= r_cnt + CW'(1);
            if ({1'b0, r_cnt} == (CW+1)'(MAXD - 1)) begin
                r_sweep    <= 1'b0;
                r_clr_corr <= 1'b0;
            end
        end else if (i_ctl.clear) begin
            r_sweep <= 1'b1;
            r_cnt   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap_we) begin
            cap_mem[cap_wa] <= cap_wd;
        end
        o_cap_rdata <= cap_mem[i_cap_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (corr_we) begin
            corr_mem[corr_wa] <= corr_wd;
        end
        o_corr_rdata <= corr_mem[i_corr_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/encoder_period_speed_meter_top.sv
`default_nettype none
// Encoder period speed meter. Each input item carries a function code in tuser
// (pulse, index, calibration request, correction load, speed query, capture
// read) and returns exactly one result item with the sector, latest interval,
// calibration status and, for queries and reads, rpm/rad-s in Q8 or a stored
// capture. Per-sector captures and the percent correction table live in two
// synchronous RAMs. Items are taken one at a time: the input is not ready until
// the result of the previous item is registered for output. A speed query passes
// a RAM read, a product stage, then two parallel bit-serial dividers of 33 steps
// each; a capture read passes a RAM read; a query while no interval exists skips them.
// After reset, and on every calibration start, a clearing pass over
// max(SECTORS*CAL_REVS, 2*SECTORS) addresses runs with the input not ready; the
// result of the starting index item is still delivered during it.
module encoder_period_speed_meter_top #(
    parameter int SECTORS  = 64,
    parameter int CAL_REVS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [47:0] time_us, [53:48] entry_sector, [54] entry_direction,
    // [57:55] entry_revolution, [73:58] correction_percent, [79:74] zero
    input  wire logic [79:0] i_s_axis_tdata,
    // [2:0] func
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [5:0] sector, [37:6] pulse_period, [38] captured, [39] calibrating,
    // [43:40] revolutions, [75:44] rpm_q8, [107:76] rad_per_sec_q8,
    // [139:108] capture_value, [143:140] zero
    output logic [143:0]     o_m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic        i_cfg_data
);
    import epsm_pkg::*;

    localparam int SW  = (SECTORS > 1) ? $clog2(SECTORS) : 1;
    localparam int RW  = $clog2(CAL_REVS + 1);
    localparam int CD  = SECTORS * CAL_REVS;
    localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
    localparam int CRW = $clog2(2 * SECTORS);

    typedef enum logic [2:0] {
        S_IDLE, S_CAPRD, S_CORRD, S_MUL, S_DIVST, S_DIVW, S_DONE
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [47:0]   r_last;
    logic [31:0]   r_iv;
    logic [SW-1:0] r_sec;
    logic          r_cal, r_pend;
    logic [RW-1:0] r_rev;
    logic          r_corr_en, r_reverse;
    logic          r_captured;
    logic [31:0]   r_rpm, r_rad, r_capv;
    logic [15:0]   r_p;
    logic [44:0]   r_num_rpm;
    logic [55:0]   r_num_rad;
    logic [42:0]   r_den;
    logic          r_out_valid;
    logic [143:0]  r_out;

    // item fields
    logic [47:0] in_time;
    logic [5:0]  in_esec;
    logic        in_edir;
    logic [2:0]  in_erev;
    logic [15:0] in_pct;
    logic        accept, slot_free, busy;
    logic        esec_ok, erev_ok, cap_ok, first_ok;
    logic [47:0] delta;
    logic [31:0] n_iv;
    logic [SW-1:0] sec_next, sec_prev;
    logic [SW+5:0] sec_ext;
    logic [RW+3:0] rev_ext;
    t_tbl_ctl    ctl;
    logic [CAW-1:0] cap_waddr, cap_raddr;
    logic [CRW-1:0] corr_waddr, corr_raddr;
    logic [31:0] cap_rdata;
    logic [15:0] corr_rdata;
    logic        div_start, done_a, done_b;
    logic [31:0] quot_a, quot_b;

    assign in_time = i_s_axis_tdata[47:0];
    assign in_esec = i_s_axis_tdata[53:48];
    assign in_edir = i_s_axis_tdata[54];
    assign in_erev = i_s_axis_tdata[57:55];
    assign in_pct  = i_s_axis_tdata[73:58];

    assign o_s_axis_tready = (r_state == S_IDLE) && !busy;
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;
    assign o_cfg_ready = 1'b1;

    assign esec_ok  = {5'b0, in_esec} < 11'(SECTORS);
    assign erev_ok  = {4'b0, in_erev} < 7'(CAL_REVS);
    assign cap_ok   = r_cal && (r_rev < RW'(CAL_REVS));
    assign first_ok = r_last != 48'd0;
    assign delta    = in_time - r_last;
    assign n_iv     = (delta[47:32] != 16'd0) ? 32'hFFFF_FFFF : delta[31:0];
    assign sec_next = (r_sec == SW'(SECTORS - 1)) ? '0 : r_sec + SW'(1);
    assign sec_prev = (r_sec == '0) ? SW'(SECTORS - 1) : r_sec - SW'(1);
    assign sec_ext  = {6'b0, r_sec};
    assign rev_ext  = {4'b0, r_rev};

    assign cap_waddr  = CAW'(r_sec) * CAW'(CAL_REVS) + CAW'(r_rev);
    assign cap_raddr  = CAW'(in_esec) * CAW'(CAL_REVS) + CAW'(in_erev);
    assign corr_waddr = CRW'({in_esec, in_edir});
    assign corr_raddr = CRW'({sec_prev, r_reverse});

    always_comb begin
        ctl = '0;
        if (accept) begin
            unique case (i_s_axis_tuser)
                FN_PULSE:     ctl.cap_we  = first_ok && cap_ok;
                FN_INDEX:     ctl.clear   = r_pend && !r_cal;
                FN_LOAD_CORR: ctl.corr_we = esec_ok;
                default:      ctl = '0;
            endcase
        end
    end

    // where an accepted item goes: speed and capture reads need more cycles
    always_comb begin
        n_state = S_DONE;
        if ((i_s_axis_tuser == FN_SPEED) && (r_iv != 32'd0)) begin
            n_state = S_CORRD;
        end else if ((i_s_axis_tuser == FN_READ_CAP) && esec_ok && erev_ok) begin
            n_state = S_CAPRD;
        end
    end

    epsm_tables #(
        .SECTORS (SECTORS),
        .CAL_REVS(CAL_REVS),
        .CAW     (CAW),
        .CRW     (CRW)
    ) u_tables (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cap_waddr (cap_waddr),
        .i_cap_wdata (n_iv),
        .i_cap_raddr (cap_raddr),
        .o_cap_rdata (cap_rdata),
        .i_corr_waddr(corr_waddr),
        .i_corr_wdata(in_pct),
        .i_corr_raddr(corr_raddr),
        .o_corr_rdata(corr_rdata),
        .o_busy      (busy)
    );

    assign div_start = (r_state == S_DIVST);

    // rpm: round(RPM_NUM*p / den)
    epsm_div u_div_rpm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (DIV_W'(r_num_rpm) + DIV_W'(r_den >> 1)),
        .i_den  (DIV_W'(r_den)),
        .o_done (done_a),
        .o_quot (quot_a)
    );

    // rad/s: round(K*p / (den << 16))
    epsm_div u_div_rad (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (DIV_W'(r_num_rad) + (DIV_W'(r_den) << 15)),
        .i_den  (DIV_W'(r_den) << 16),
        .o_done (done_b),
        .o_quot (quot_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_iv        <= '0;
            r_sec       <= '0;
            r_cal       <= 1'b0;
            r_pend      <= 1'b0;
            r_rev       <= '0;
            r_corr_en   <= 1'b0;
            r_reverse   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == {1'b0, CFG_CORR_EN}) begin
                    r_corr_en <= i_cfg_data;
                end else if (i_cfg_index == {1'b0, CFG_REVERSE}) begin
                    r_reverse <= i_cfg_data;
                end
            end
            if ((r_state == S_DONE) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_captured <= ctl.cap_we;
                        r_rpm      <= '0;
                        r_rad      <= '0;
                        r_capv     <= '0;
                        r_state    <= n_state;
                        unique case (i_s_axis_tuser)
                            FN_PULSE: begin
                                if (first_ok) begin
                                    r_iv <= n_iv;
                                end
                                r_last <= in_time;
                                r_sec  <= sec_next;
                            end
                            FN_INDEX: begin
                                r_sec <= '0;
                                if (r_pend && !r_cal) begin
                                    r_cal  <= 1'b1;
                                    r_pend <= 1'b0;
                                    r_rev  <= '0;
                                end else if (cap_ok) begin
                                    r_rev <= r_rev + RW'(1);
                                end
                            end
                            FN_CAL_REQ: r_pend <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                S_CAPRD: begin
                    r_capv  <= cap_rdata;
                    r_state <= S_DONE;
                end
                S_CORRD: begin
                    r_p     <= r_corr_en ? corr_rdata : PCT_NEUTRAL;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_num_rpm <= 45'(RPM_NUM) * 45'(r_p);
                    r_num_rad <= 56'(RAD_NUM_Q16) * 56'(r_p);
                    r_den     <= 43'(SECTORS) * 43'(r_iv);
                    r_state   <= S_DIVST;
                end
                S_DIVST: r_state <= S_DIVW;
                S_DIVW: begin
                    if (done_a) begin
                        r_rpm   <= quot_a;
                        r_rad   <= quot_b;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_out <= {4'b0, r_capv, r_rad, r_rpm, rev_ext[3:0], r_cal,
                                  r_captured, r_iv, sec_ext[5:0]};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_rev_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rev <= RW'(CAL_REVS))
        else $error("revolution count past limit");

    a_sec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_sec} < (SW+1)'(SECTORS))
        else $error("sector count out of range");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_a |-> (r_state == S_DIVW) && done_b)
        else $error("divider finished outside wait state");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("item accepted without leaving idle");

endmodule
`default_nettype wire

FILE: dv/tb_encoder_period_speed_meter_top.sv
`default_nettype none
// Checks the encoder period speed meter: items go in through the stream
// slave port, each item's reading is predicted at acceptance and compared
// field by field with the result items leaving the master port.
module tb_encoder_period_speed_meter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import epsm_pkg::*;

    localparam int NSEC = 64;
    localparam int NREV = 8;
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;
    localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;
    localparam longint unsigned SAT32 = 64'hFFFF_FFFF;
    localparam longint unsigned RPM_K = 64'd153600000;
    localparam longint unsigned RAD_K = 64'd1054143570666;
    localparam int DRAIN_CYC = 80;     // well past the slowest item (speed query)

    typedef struct {
        logic [2:0]  func;
        logic [47:0] t_us;
        logic [5:0]  esec;
        logic        edir;
        logic [2:0]  erev;
        logic [15:0] pct;
    } enc_item_t;

    typedef struct {
        logic [5:0]  sector;
        logic [31:0] ivl;
        logic        captured;
        logic        cal;
        logic [3:0]  revs;
        logic [31:0] rpm;
        logic [31:0] rad;
        logic [31:0] capv;
    } reading_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [79:0]  s_data = '0;
    logic [2:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [143:0] m_data;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic         cfg_data = 1'b0;

    encoder_period_speed_meter_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------- meter model state ----------------
    logic [47:0] enc_last_time = '0;
    logic [31:0] enc_interval = '0;
    logic [5:0]  enc_sector = '0;
    logic        cal_on = 1'b0;
    logic        cal_armed = 1'b0;
    logic [3:0]  rev_cnt = '0;
    logic [31:0] cap_store [NSEC][NREV];
    logic        cap_ok [NSEC][NREV];
    logic [15:0] pct_table [NSEC][2];
    logic        corr_en = 1'b0;
    logic        rev_dir = 1'b0;

    enc_item_t pending_items [$];
    reading_t  exp_readings [$];
    int        n_errors = 0;

    function automatic logic [31:0] div_round_clip(longint unsigned num, longint unsigned den);
        longint unsigned q;
        q = (num + den / 2) / den;
        return (q > SAT32) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // apply one accepted item to the model and queue the reading it yields
    task automatic meter_predict(input enc_item_t it);
        reading_t r;
        logic [47:0] d;
        logic [5:0] prev;
        longint unsigned p, den;
        r.captured = 1'b0;
        r.rpm = '0;
        r.rad = '0;
        r.capv = '0;
        case (it.func)
            FN_PULSE: begin
                if (enc_last_time != 0) begin
                    d = it.t_us - enc_last_time;   // wraps mod 2^48
                    enc_interval = (d > SAT32) ? 32'hFFFF_FFFF : d[31:0];
                    if (cal_on && rev_cnt < NREV) begin
                        cap_store[enc_sector][rev_cnt[2:0]] = enc_interval;
                        cap_ok[enc_sector][rev_cnt[2:0]] = 1'b1;
                        r.captured = 1'b1;
                    end
                end
                enc_last_time = it.t_us;
                enc_sector = enc_sector + 6'd1;
            end
            FN_INDEX: begin
                enc_sector = '0;
                if (cal_armed && !cal_on) begin
                    cal_on = 1'b1;
                    cal_armed = 1'b0;
                    rev_cnt = '0;
                    foreach (cap_ok[i, j]) begin
                        cap_ok[i][j] = 1'b0;
                        cap_store[i][j] = '0;
                    end
                end else if (cal_on && rev_cnt < NREV) begin
                    rev_cnt = rev_cnt + 4'd1;
                end
            end
            FN_CAL_REQ: cal_armed = 1'b1;
            FN_LOAD_CORR: pct_table[it.esec][it.edir] = it.pct;
            FN_SPEED: begin
                if (enc_interval != 0) begin
                    // correction follows the sector just left
                    prev = enc_sector - 6'd1;
                    p = corr_en ? longint'(pct_table[prev][rev_dir]) : 64'd100;
                    den = 64'(NSEC) * longint'(enc_interval);
                    r.rpm = div_round_clip(RPM_K * p, den);
                    r.rad = div_round_clip(RAD_K * p, den << 16);
                end
            end
            FN_READ_CAP: begin
                if (cap_ok[it.esec][it.erev]) r.capv = cap_store[it.esec][it.erev];
            end
            default: ;
        endcase
        r.sector = enc_sector;
        r.ivl = enc_interval;
        r.cal = cal_on;
        r.revs = rev_cnt;
        exp_readings.push_back(r);
    endtask

    task automatic check_field(input string fname, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $display("%0t ns: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                     $time, fname, e, e, a, a);
            n_errors++;
        end
    endtask

    // ---------------- slave side driver ----------------
    enc_item_t cur_item;
    logic s_took = 1'b0;
    logic m_took = 1'b0;
    int   s_gap = 0;
    int   m_wait = 0;
    bit   no_idle = 1'b0;      // stretches without gaps or stalls

    always @(posedge clk) begin
        s_took <= s_valid && s_ready;
        m_took <= m_valid && m_ready;
        if (rst_n && s_valid && s_ready) meter_predict(cur_item);
    end

    always @(negedge clk) begin
        if (rst_n && (!s_valid || s_took)) begin
            if (s_took) s_gap = no_idle ? 0 : $urandom_range(0, 8);
            if (s_gap > 0) begin
                s_valid <= 1'b0;
                s_gap--;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_valid <= 1'b1;
                s_user  <= cur_item.func;
                s_data  <= {6'b0, cur_item.pct, cur_item.erev, cur_item.edir,
                            cur_item.esec, cur_item.t_us};
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- master side: stalls and checking ----------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (m_took) m_wait = no_idle ? 0 : $urandom_range(0, 8);
            if (m_wait > 0) begin
                m_ready <= 1'b0;
                m_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        reading_t e;
        if (rst_n && m_valid && m_ready) begin
            if (exp_readings.size() == 0) begin
                $display("%0t ns: result item with none expected, got 0x%0h", $time, m_data);
                n_errors++;
            end else begin
                e = exp_readings.pop_front();
                check_field("sector", 32'(e.sector), 32'(m_data[5:0]));
                check_field("pulse_period", e.ivl, m_data[37:6]);
                check_field("captured", 32'(e.captured), 32'(m_data[38]));
                check_field("calibrating", 32'(e.cal), 32'(m_data[39]));
                check_field("revolutions", 32'(e.revs), 32'(m_data[43:40]));
                check_field("rpm_q8", e.rpm, m_data[75:44]);
                check_field("rad_per_sec_q8", e.rad, m_data[107:76]);
                check_field("capture_value", e.capv, m_data[139:108]);
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic add_item(input logic [2:0] f, input logic [47:0] t,
                            input logic [5:0] es, input logic ed,
                            input logic [2:0] er, input logic [15:0] pc);
        enc_item_t it;
        it.func = f;
        it.t_us = t;
        it.esec = es;
        it.edir = ed;
        it.erev = er;
        it.pct = pc;
        pending_items.push_back(it);
    endtask

    // item whose unused fields carry noise
    task automatic add_noise_item(input logic [2:0] f, input logic [15:0] pc);
        add_item(f, 48'({$urandom, $urandom}), 6'($urandom), 1'($urandom),
                 3'($urandom), pc);
    endtask

    // wait until every queued item went through and every reading came back
    task automatic drain();
        while (pending_items.size() > 0 || s_valid || exp_readings.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == 2'(CFG_CORR_EN)) corr_en = v;
        else rev_dir = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    logic [47:0] tnow = 48'd1000;

    // mostly steady rotation with queries, plus odd timestamps and noise
    task automatic random_phase(input int n);
        int k;
        logic [47:0] big;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 48) begin
                case ($urandom_range(0, 19))
                    0: tnow = '0;
                    1: begin
                        big = 48'({$urandom, $urandom});
                        tnow = big;
                    end
                    2: tnow = tnow + {16'($urandom), 32'($urandom)};
                    default: tnow = tnow + 48'($urandom_range(1, 6000));
                endcase
                add_item(FN_PULSE, tnow, 6'($urandom), 1'($urandom), 3'($urandom),
                         16'($urandom));
            end else if (k < 56) begin
                add_noise_item(FN_INDEX, 16'($urandom));
            end else if (k < 58) begin
                add_noise_item(FN_CAL_REQ, 16'($urandom));
            end else if (k < 68) begin
                add_noise_item(FN_LOAD_CORR,
                               ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 250)));
            end else if (k < 84) begin
                add_noise_item(FN_SPEED, 16'($urandom));
            end else if (k < 97) begin
                add_noise_item(FN_READ_CAP, 16'($urandom));
            end else begin
                add_noise_item($urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7,
                               16'($urandom));
            end
        end
    endtask

    initial begin
        foreach (pct_table[i, j]) pct_table[i][j] = 16'd100;
        foreach (cap_ok[i, j]) begin
            cap_ok[i][j] = 1'b0;
            cap_store[i][j] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty state, first pulses, wrap, saturation, calibration
        add_item(FN_SPEED, '0, '0, 1'b0, '0, '0);
        add_item(FN_READ_CAP, '0, 6'd63, 1'b1, 3'd7, '0);
        add_item(FN_PULSE, 48'd1000, '0, 1'b0, '0, '0);      // first pulse, no interval
        add_item(FN_PULSE, 48'd1500, '0, 1'b0, '0, '0);
        add_item(FN_SPEED, '0, '0, 1'b0, '0, '0);
        add_item(FN_LOAD_CORR, '0, 6'd1, 1'b0, '0, 16'd0);   // zero percent
        add_item(FN_LOAD_CORR, '0, 6'd1, 1'b1, '0, 16'hFFFF);
        add_item(FN_LOAD_CORR, '0, 6'd63, 1'b1, 3'd7, 16'd1);
        add_item(FN_PULSE, '0, '0, 1'b0, '0, '0);            // wraps, saturates
        add_item(FN_PULSE, 48'd10, '0, 1'b0, '0, '0);        // after time zero: first again
        add_item(FN_PULSE, T_MAX, 6'd63, 1'b1, 3'd7, 16'hFFFF);
        add_item(FN_PULSE, 48'd4, '0, 1'b0, '0, '0);         // wrap to interval 5
        add_item(FN_PULSE, 48'd5, '0, 1'b0, '0, '0);         // interval 1
        add_item(FN_SPEED, T_MAX, 6'd63, 1'b1, 3'd7, 16'hFFFF);
        add_item(FN_CAL_REQ, '0, '0, 1'b0, '0, '0);
        add_item(FN_INDEX, '0, '0, 1'b0, '0, '0);            // calibration starts
        add_item(FN_PULSE, 48'd305, '0, 1'b0, '0, '0);
        add_item(FN_PULSE, 48'd700, '0, 1'b0, '0, '0);
        add_item(FN_READ_CAP, '0, 6'd0, 1'b0, 3'd0, '0);
        add_item(FN_READ_CAP, '0, 6'd1, 1'b0, 3'd0, '0);
        add_item(FN_INDEX, '0, '0, 1'b0, '0, '0);
        add_item(FN_PULSE, 48'd900, '0, 1'b0, '0, '0);
        add_item(FN_READ_CAP, '0, 6'd0, 1'b0, 3'd1, '0);
        add_item(FN_SPARE6, T_MAX, 6'd63, 1'b1, 3'd7, 16'hFFFF);
        add_item(FN_SPARE7, '0, '0, 1'b0, '0, '0);
        tnow = 48'd900;
        drain();

        // random phases, each under its own register setting; the sender
        // holds off at every boundary until all readings are back
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(2'(CFG_CORR_EN), (ph < 2));
            write_reg(2'(CFG_REVERSE), (ph == 1 || ph == 2));
            no_idle = (ph == 2);
            random_phase(132);
            drain();
        end

        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
